### sv/cuckoo_hash_insert_unit_macros.svh
// Assertion macros for the cuckoo hash insert unit.
`ifndef CUCKOO_HASH_INSERT_UNIT_MACROS_SVH
`define CUCKOO_HASH_INSERT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define CHI_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) \
        else $error("cuckoo hash insert unit: check failed");
// Checked on every edge, reset included.
`define CHI_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) expr) \
        else $error("cuckoo hash insert unit: check failed");
`else
`define CHI_ASSERT(lbl, expr)
`define CHI_ASSERT_ALWAYS(lbl, expr)
`endif

`endif

### sv/chi_pkg.sv
// Types, constants and hash helpers for the cuckoo hash insert unit.
package chi_pkg;

    localparam int KEY_W      = 32;
    localparam int SLOTS      = 13;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int NIB_W      = 4;
    localparam int HASH_STEPS = KEY_W / NIB_W;
    localparam int CNT_W      = $clog2(HASH_STEPS);

    localparam logic [7:0] FIRST_MOD      = 8'd13;
    localparam logic [7:0] SECOND_MOD     = 8'd11;
    localparam logic [7:0] KICK_LIMIT_RST = 8'd26;
    localparam logic [7:0] KICK_MAX       = 8'd255;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_FAILED = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic             table_select;
        logic [3:0]       slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  kicks;
        logic        read_valid;
        logic [31:0] read_key;
    } t_rsp;

    // Stored entry keeps both slot indexes so an evicted key needs no rehash.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] h1;
        logic [SLOT_W-1:0] h2;
    } t_entry;

    // Reduce v < 16*m to v mod m by conditional subtraction of m*8, m*4, m*2, m.
    function automatic logic [SLOT_W-1:0] mod_fold(input logic [7:0] v, input logic [7:0] m);
        logic [7:0] r;
        logic [7:0] sub;
        r = v;
        for (int k = 3; k >= 0; k--) begin
            sub = m << k;
            if (r >= sub) begin
                r = r - sub;
            end
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

### sv/cuckoo_hash_insert_unit.sv
// Top level of the two-table cuckoo hash insert unit.
//
//  port group              dir  handshake              content
//  start / i_req / busy    in   start & !busy          t_req: insert a key or read a slot
//  o_valid / o_rsp         out  one-cycle strobe       t_rsp: insert status or slot contents
//  i_cfg_we / i_cfg_wdata  in   write on i_cfg_we      kick_limit
//
// Insert: nibble-serial hashing in S_HASH, then per eviction a table read in S_PROBE
// and write-back and swap in S_SWAP; the result strobe follows the final probe.
// Read: from accept to strobe through the registered table read and S_READ.
// One transaction at a time; busy is high until the result is registered.
// Synchronous reset clears valid bits, control state and kick_limit (26).
// The receiver cannot stall; each result is shown for one cycle.
`include "cuckoo_hash_insert_unit_macros.svh"

module cuckoo_hash_insert_unit
    import chi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_valid,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_PROBE = 5'b00100,
        S_SWAP  = 5'b01000,
        S_READ  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [KEY_W-1:0]  r_cur, n_cur;
    logic [SLOT_W-1:0] r_h1, n_h1;
    logic [SLOT_W-1:0] r_h2, n_h2;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [7:0]        r_kick, n_kick;
    logic [KEY_W-1:0]  r_orig, n_orig;
    logic              r_ret, n_ret;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_tbl, n_tbl;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_limit;
    logic              r_valid, n_valid;
    t_rsp              r_rsp, n_rsp;

    logic [SLOTS-1:0]  r_vld0, r_vld1;

    // table memories
    t_entry            r_mem0 [SLOTS];
    t_entry            r_mem1 [SLOTS];
    t_entry            r_rdata0, r_rdata1;

    logic              rd_en0, rd_en1, wr_en0, wr_en1;
    logic [SLOT_W-1:0] rd_slot, wr_slot;
    t_entry            wr_data;
    logic              vld_set;

    // probe-stage decode
    logic              p_tbl;
    logic [SLOT_W-1:0] p_slot;
    logic              p_occ;
    logic [7:0]        p_kick;
    logic              p_first;
    logic [KEY_W-1:0]  p_orig;
    logic              p_ret;
    logic              p_hit;
    logic [NIB_W-1:0]  nib;
    logic [SLOT_W-1:0] f2;
    logic              hash_last;
    logic              rd_hit;
    t_entry            swap_data;

    always_comb begin
        p_tbl     = r_kick[0];
        p_slot    = p_tbl ? r_h2 : r_h1;
        p_occ     = p_tbl ? r_vld1[p_slot] : r_vld0[p_slot];
        p_kick    = r_kick + 8'd1;
        p_first   = (r_kick == 8'd0);
        p_orig    = p_first ? r_cur : r_orig;
        p_ret     = p_first ? 1'b0 : r_ret;
        p_hit     = (r_cur == p_orig) && (p_kick > r_limit);
        nib       = r_cur[KEY_W-1 -: NIB_W];
        f2        = mod_fold({r_h2, nib}, SECOND_MOD);
        hash_last = (r_cnt == CNT_W'(HASH_STEPS - 1));
        rd_hit    = r_rd_ok && (r_tbl ? r_vld1[r_slot] : r_vld0[r_slot]);
        swap_data = r_tbl ? r_rdata1 : r_rdata0;
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_h1    = r_h1;
        n_h2    = r_h2;
        n_cnt   = r_cnt;
        n_kick  = r_kick;
        n_orig  = r_orig;
        n_ret   = r_ret;
        n_slot  = r_slot;
        n_tbl   = r_tbl;
        n_rd_ok = r_rd_ok;
        n_rsp   = r_rsp;
        n_valid = 1'b0;
        rd_en0  = 1'b0;
        rd_en1  = 1'b0;
        wr_en0  = 1'b0;
        wr_en1  = 1'b0;
        rd_slot = p_slot;
        wr_slot = r_slot;
        wr_data = '{key: r_cur, h1: r_h1, h2: r_h2};
        vld_set = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_req.req_type == REQ_READ) begin
                        n_rd_ok = (i_req.slot_index < 4'(SLOTS));
                        n_tbl   = i_req.table_select;
                        n_slot  = n_rd_ok ? i_req.slot_index[SLOT_W-1:0] : '0;
                        rd_slot = n_slot;
                        rd_en0  = n_rd_ok && !i_req.table_select;
                        rd_en1  = n_rd_ok && i_req.table_select;
                        n_state = S_READ;
                    end else begin
                        n_cur   = i_req.key;
                        n_h1    = '0;
                        n_h2    = '0;
                        n_cnt   = '0;
                        n_kick  = '0;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                // rotate a nibble per cycle; after the last step the key is back in place
                n_cur = {r_cur[KEY_W-NIB_W-1:0], nib};
                n_h1  = mod_fold({r_h1, nib}, FIRST_MOD);
                n_h2  = hash_last ? (SECOND_MOD[SLOT_W-1:0] - f2) : f2;
                n_cnt = r_cnt + CNT_W'(1);
                if (hash_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!p_occ) begin
                    wr_en0  = !p_tbl;
                    wr_en1  = p_tbl;
                    wr_slot = p_slot;
                    n_tbl   = p_tbl;
                    n_slot  = p_slot;
                    vld_set = 1'b1;
                    n_rsp   = '{status: ST_PLACED, kicks: r_kick, read_valid: 1'b0,
                                read_key: '0};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_kick == KICK_MAX) begin
                    n_rsp   = '{status: ST_FAILED, kicks: KICK_MAX, read_valid: 1'b0,
                                read_key: '0};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (p_hit && p_ret) begin
                    // original key back a second time past the limit
                    n_rsp   = '{status: ST_FAILED, kicks: p_kick, read_valid: 1'b0,
                                read_key: '0};
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_kick  = p_kick;
                    n_orig  = p_orig;
                    n_ret   = p_ret | p_hit;
                    n_tbl   = p_tbl;
                    n_slot  = p_slot;
                    rd_en0  = !p_tbl;
                    rd_en1  = p_tbl;
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                // occupant was read last cycle; store key in hand, carry occupant on
                wr_en0  = !r_tbl;
                wr_en1  = r_tbl;
                n_cur   = swap_data.key;
                n_h1    = swap_data.h1;
                n_h2    = swap_data.h2;
                n_state = S_PROBE;
            end
            S_READ: begin
                n_rsp   = '{status: ST_READ, kicks: 8'd0, read_valid: rd_hit,
                            read_key: rd_hit ? swap_data.key : '0};
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kick  <= '0;
            r_cnt   <= '0;
            r_orig  <= '0;
            r_ret   <= 1'b0;
            r_limit <= KICK_LIMIT_RST;
            r_valid <= 1'b0;
            r_vld0  <= '0;
            r_vld1  <= '0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
            r_cnt   <= n_cnt;
            r_orig  <= n_orig;
            r_ret   <= n_ret;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (vld_set && !n_tbl) begin
                r_vld0[n_slot] <= 1'b1;
            end
            if (vld_set && n_tbl) begin
                r_vld1[n_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_h1    <= n_h1;
        r_h2    <= n_h2;
        r_slot  <= n_slot;
        r_tbl   <= n_tbl;
        r_rd_ok <= n_rd_ok;
        r_rsp   <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en0) begin
            r_mem0[wr_slot] <= wr_data;
        end
        if (rd_en0) begin
            r_rdata0 <= r_mem0[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en1) begin
            r_mem1[wr_slot] <= wr_data;
        end
        if (rd_en1) begin
            r_rdata1 <= r_mem1[rd_slot];
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `CHI_ASSERT(a_result_when_idle, o_valid |-> !busy)
    `CHI_ASSERT(a_no_result_after_accept, (start && !busy) |=> !o_valid)
    `CHI_ASSERT(a_swap_slot_occupied,
        (r_state == S_SWAP) |-> (r_tbl ? r_vld1[r_slot] : r_vld0[r_slot]))
    `CHI_ASSERT(a_probe_slots_in_range,
        (r_state == S_PROBE) |-> (r_h1 < SLOT_W'(SLOTS) && r_h2 != '0
            && r_h2 <= SECOND_MOD[SLOT_W-1:0]))
    `CHI_ASSERT(a_empty_read_zero_key,
        (o_valid && o_rsp.status == ST_READ && !o_rsp.read_valid) |-> (o_rsp.read_key == '0))

endmodule

### tb/cuckoo_hash_insert_unit_test.sv
// Self-checking testbench for the two-table cuckoo hash insert unit.

class cuckoo_shadow;
    logic [31:0]   slot_key  [2][13];
    bit            slot_used [2][13];
    logic [31:0]   chain_origin;
    bit            origin_back;
    logic [7:0]    kick_limit;
    chi_pkg::t_rsp pending_rsp [$];
    int            errors;
    int            n_placed;
    int            n_rejected;
    int            n_capped;
    int            n_reads;
    int            n_read_hits;
    int            longest_chain;

    function new();
        foreach (slot_used[t, s]) begin
            slot_used[t][s] = 1'b0;
            slot_key[t][s]  = '0;
        end
        chain_origin  = '0;
        origin_back   = 1'b0;
        kick_limit    = chi_pkg::KICK_LIMIT_RST;
        errors        = 0;
        n_placed      = 0;
        n_rejected    = 0;
        n_capped      = 0;
        n_reads       = 0;
        n_read_hits   = 0;
        longest_chain = 0;
    endfunction

    function int home_slot(logic [31:0] k, bit tbl);
        if (tbl)
            return int'(chi_pkg::SECOND_MOD) - int'(k % chi_pkg::SECOND_MOD);
        return int'(k % chi_pkg::FIRST_MOD);
    endfunction

    // Walk the eviction chain for one key; tables are updated in place.
    function chi_pkg::t_rsp place_key(logic [31:0] key);
        chi_pkg::t_rsp r;
        logic [31:0]   hand;
        logic [31:0]   evicted;
        int            kcount;
        bit            tbl;
        int            where;
        r        = '0;
        r.status = chi_pkg::ST_FAILED;
        hand     = key;
        kcount   = 0;
        while (1) begin
            tbl   = bit'(kcount & 1);
            where = home_slot(hand, tbl);
            if (!slot_used[tbl][where]) begin
                slot_key[tbl][where]  = hand;
                slot_used[tbl][where] = 1'b1;
                r.status = chi_pkg::ST_PLACED;
                r.kicks  = 8'(kcount);
                break;
            end
            if (kcount >= int'(chi_pkg::KICK_MAX)) begin
                r.kicks = chi_pkg::KICK_MAX;
                n_capped++;
                break;
            end
            kcount++;
            if (kcount == 1) begin
                chain_origin = hand;
                origin_back  = 1'b0;
            end
            if (hand == chain_origin && kcount > int'(kick_limit)) begin
                if (origin_back) begin
                    r.kicks = 8'(kcount);
                    break;
                end
                origin_back = 1'b1;
            end
            evicted              = slot_key[tbl][where];
            slot_key[tbl][where] = hand;
            hand                 = evicted;
        end
        if (int'(r.kicks) > longest_chain)
            longest_chain = int'(r.kicks);
        return r;
    endfunction

    function void set_limit(logic [7:0] v);
        kick_limit = v;
    endfunction

    function int pending();
        return pending_rsp.size();
    endfunction

    function void accept(chi_pkg::t_req q);
        chi_pkg::t_rsp r;
        if (q.req_type == chi_pkg::REQ_READ) begin
            r        = '0;
            r.status = chi_pkg::ST_READ;
            n_reads++;
            if (q.slot_index < chi_pkg::SLOTS && slot_used[q.table_select][q.slot_index]) begin
                r.read_valid = 1'b1;
                r.read_key   = slot_key[q.table_select][q.slot_index];
                n_read_hits++;
            end
        end else begin
            r = place_key(q.key);
            if (r.status == chi_pkg::ST_PLACED)
                n_placed++;
            else
                n_rejected++;
        end
        pending_rsp = {pending_rsp, r};
    endfunction

    task report(string what);
        errors++;
        $display("ERROR: %s", what);
    endtask

    task compare(chi_pkg::t_rsp got);
        chi_pkg::t_rsp want;
        if (pending_rsp.size() == 0) begin
            report($sformatf("result with nothing pending: status %0d kicks %0d",
                             got.status, got.kicks));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.kicks !== want.kicks)
            report($sformatf("kicks %0d, want %0d", got.kicks, want.kicks));
        if (got.read_valid !== want.read_valid)
            report($sformatf("read_valid %b, want %b", got.read_valid, want.read_valid));
        if (got.read_key !== want.read_key)
            report($sformatf("read_key %h, want %h", got.read_key, want.read_key));
    endtask
endclass

module cuckoo_hash_insert_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import chi_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int PHASE_ITEMS   = 320;
    localparam int RECENT_DEPTH  = 32;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_valid;
    t_rsp       o_rsp;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    cuckoo_shadow shadow;
    logic [31:0]  recent_keys [$];
    int           cycle_count = 0;
    logic [7:0]   limit_plan [6];

    cuckoo_hash_insert_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Results cannot be held off: every strobe is checked at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0)
            shadow.compare(o_rsp);
    end

    function automatic t_req make_req(logic rt, logic [31:0] k, logic tbl, logic [3:0] idx);
        t_req q;
        q.req_type     = rt;
        q.key          = k;
        q.table_select = tbl;
        q.slot_index   = idx;
        return q;
    endfunction

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = $urandom;
            4, 5:       k = $urandom_range(0, 63);
            6, 7:       k = (recent_keys.size() == 0) ? $urandom :
                            recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            8:          k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            // multiples of 143 all hash to the same pair of slots
            default:    k = 32'd143 * 32'($urandom_range(0, 30_000_000));
        endcase
        recent_keys = {recent_keys, k};
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
        return k;
    endfunction

    // Reads go only to slots that hold a key, or past the end of the table.
    function automatic t_req make_item();
        t_req q;
        int   hits [$];
        bit   tbl;
        q = make_req(REQ_INSERT, 32'($urandom), 1'($urandom_range(0, 1)),
                     4'($urandom_range(0, 15)));
        if ($urandom_range(0, 99) < 55) begin
            q.key = pick_key();
        end else begin
            tbl = 1'($urandom_range(0, 1));
            for (int s = 0; s < SLOTS; s++)
                if (shadow.slot_used[tbl][s])
                    hits = {hits, s};
            q.req_type     = REQ_READ;
            q.table_select = tbl;
            if (hits.size() == 0 || $urandom_range(0, 7) == 0)
                q.slot_index = 4'($urandom_range(SLOTS, 15));
            else
                q.slot_index = 4'(hits[$urandom_range(0, hits.size() - 1)]);
        end
        return q;
    endfunction

    function automatic int next_gap(int n);
        int r;
        if (n % 128 < 32)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // Called on a clock edge; returns on the edge that accepts the transaction.
    task automatic issue(input t_req q);
        i_req <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        shadow.accept(q);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow.set_limit(v);
    endtask

    initial begin
        int g;
        shadow      = new();
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset kick limit.
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd13));
        issue(make_req(REQ_READ,   32'hFFFF_FFFF, 1'b1, 4'd15));
        issue(make_req(REQ_INSERT, 32'h0,         1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'hFFFF_FFFF, 1'b1, 4'd15));
        issue(make_req(REQ_INSERT, 32'h0,         1'b0, 4'd0));  // duplicate moves to table two
        issue(make_req(REQ_INSERT, 32'h0,         1'b1, 4'd0));  // ping-pong until rejected
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd0));
        issue(make_req(REQ_READ,   32'h0,         1'b1, 4'd11));
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd8));
        issue(make_req(REQ_INSERT, 32'd13,        1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'd26,        1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'h8000_0000, 1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'd12,        1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'd11,        1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'd143,       1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'h5555_5555, 1'b1, 4'd5));
        issue(make_req(REQ_INSERT, 32'hAAAA_AAAA, 1'b0, 4'd10));
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd12));
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd11));
        issue(make_req(REQ_READ,   32'h0,         1'b1, 4'd14));
        issue(make_req(REQ_READ,   32'h0,         1'b0, 4'd0));
        // Largest limit: a duplicate key ping-pongs until the kick cap.
        write_limit(8'd255);
        issue(make_req(REQ_INSERT, 32'h0,         1'b0, 4'd0));
        issue(make_req(REQ_READ,   32'h0,         1'b1, 4'd11));
        // Zero limit: every eviction is already past it.
        write_limit(8'd0);
        issue(make_req(REQ_INSERT, 32'h0,         1'b0, 4'd0));
        issue(make_req(REQ_INSERT, 32'd13,        1'b0, 4'd0));

        limit_plan[0] = 8'd1;
        limit_plan[1] = 8'd255;
        limit_plan[2] = 8'd0;
        limit_plan[3] = 8'($urandom_range(2, 254));
        limit_plan[4] = KICK_LIMIT_RST;
        limit_plan[5] = 8'($urandom_range(1, 254));
        foreach (limit_plan[p]) begin
            write_limit(limit_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                g = next_gap(n);
                if (g > 0) begin
                    start <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                issue(make_item());
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        $display("Covered %0d inserts (%0d placed, %0d rejected, %0d at the kick cap),",
                 shadow.n_placed + shadow.n_rejected, shadow.n_placed, shadow.n_rejected,
                 shadow.n_capped);
        $display("%0d reads (%0d hits); kick limits 26, 255, 0, 1 and random values;",
                 shadow.n_reads, shadow.n_read_hits);
        $display("longest chain %0d, %0d mismatches.", shadow.longest_chain, shadow.errors);
        if (shadow.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
